[hdl/contiguous_fit_allocator_core_defines.svh]
// assertion macros for the allocator core
`ifndef CONTIGUOUS_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define CFA_ASSERT(lbl, clkk, rstt, prop, msg) \
  lbl: assert property (@(posedge clkk) disable iff (rstt) prop) else $error(msg);
`define CFA_ASSERT_RST(lbl, clkk, prop, msg) \
  lbl: assert property (@(posedge clkk) prop) else $error(msg);
`else
`define CFA_ASSERT(lbl, clkk, rstt, prop, msg)
`define CFA_ASSERT_RST(lbl, clkk, prop, msg)
`endif
`endif

[hdl/cfa_pkg.sv]
package cfa_pkg;
  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int ID_BITS_DEF = 16;
  localparam logic [31:0] TOTAL_RESET = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_INIT = 2'd0, KIND_ALLOC = 2'd1, KIND_RELEASE = 2'd2, KIND_COMPACT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOFIT = 2'd1, ST_FULL = 2'd2, ST_NOID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0, POL_BEST = 2'd1, POL_WORST = 2'd2, POL_SPARE = 2'd3
  } policy_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_SPLIT_CHK, S_SHIFT, S_SPLIT_WR, S_MARK,
    S_RELEASE, S_COMPACT, S_COMPACT_TOP, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch input item, clear walk state
    logic do_init;
    logic scan_step; // examine entry at idx for allocation
    logic park;      // move idx to the table end before the shift
    logic shift_step;
    logic split_wr;
    logic mark;
    logic rel_step;
    logic cmp_step;
    logic cmp_top;
    logic set_result;
    status_t status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_end;
    logic found;
    logic exact;
    logic full;
    logic early;   // first fit found, stop scanning
    logic shift_end;
    logic hit;
    logic any_free;
  } sts_t;
endpackage

[hdl/cfa_datapath.sv]
module cfa_datapath #(
  parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF,
  parameter int ID_BITS = cfa_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfa_pkg::cmd_t cmd,
  output cfa_pkg::sts_t sts,
  input  logic [1:0]  fit_policy,
  input  logic [31:0] total_space,
  input  logic [31:0] request_size,
  input  logic [15:0] target_id,
  output logic [1:0]  res_status,
  output logic [15:0] res_id,
  output logic [31:0] res_base
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  // table held as a row of registers, each entry at its own place and the walk
  // touching one or two entries per cycle
  logic [31:0] seg_base [MAX_SEGMENTS];
  logic [31:0] seg_size [MAX_SEGMENTS];
  logic [ID_BITS-1:0] seg_ident [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] seg_used;
  logic [CW-1:0] seg_count;
  logic [ID_BITS-1:0] id_counter;

  logic [31:0] req;
  logic [15:0] tid;
  logic [CW-1:0] idx, widx, pick;
  logic found, hit, any_free;
  logic [31:0] addr, freemem;

  logic [IW-1:0] i_lo, p_lo, w_lo, i_m1;
  logic [31:0] cur_size, pick_size;
  logic fits, better;
  logic [ID_BITS-1:0] fresh;

  assign i_lo = idx[IW-1:0];
  assign i_m1 = IW'(idx - CW'(1));
  assign p_lo = pick[IW-1:0];
  assign w_lo = widx[IW-1:0];
  assign cur_size = seg_size[i_lo];
  assign pick_size = seg_size[p_lo];
  assign fresh = id_counter + ID_BITS'(1);
  assign fits = !seg_used[i_lo] && (cur_size >= req);

  always_comb begin
    better = 1'b0;
    if (!found) better = 1'b1;
    else if (fit_policy == cfa_pkg::POL_BEST) better = cur_size < pick_size;
    else if (fit_policy == cfa_pkg::POL_WORST) better = cur_size > pick_size;
  end

  assign sts.idx_end = (idx >= seg_count);
  assign sts.found = found;
  assign sts.exact = (pick_size == req);
  assign sts.full = (seg_count >= CW'(MAX_SEGMENTS));
  assign sts.early = found && fit_policy != cfa_pkg::POL_BEST
                     && fit_policy != cfa_pkg::POL_WORST;
  assign sts.shift_end = (idx <= pick + CW'(1));
  assign sts.hit = hit;
  assign sts.any_free = any_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_used <= '0;
      seg_count <= '0;
      id_counter <= '0;
    end else begin
      if (cmd.do_init) begin
        seg_base[0] <= '0;
        seg_size[0] <= total_space;
        seg_ident[0] <= '0;
        seg_used <= '0;
        seg_count <= CW'(1);
        id_counter <= '0;
      end
      if (cmd.shift_step) begin
        seg_base[i_lo] <= seg_base[i_m1];
        seg_size[i_lo] <= seg_size[i_m1];
        seg_ident[i_lo] <= seg_ident[i_m1];
        seg_used[i_lo] <= seg_used[i_m1];
      end
      if (cmd.split_wr) begin
        seg_base[IW'(pick + CW'(1))] <= seg_base[p_lo] + req;
        seg_size[IW'(pick + CW'(1))] <= pick_size - req;
        seg_used[IW'(pick + CW'(1))] <= 1'b0;
        seg_ident[IW'(pick + CW'(1))] <= fresh;
        seg_size[p_lo] <= req;
        id_counter <= fresh;
        seg_count <= seg_count + CW'(1);
      end
      if (cmd.mark) seg_used[p_lo] <= 1'b1;
      if (cmd.rel_step && seg_ident[i_lo][ID_BITS-1:0] == ID_BITS'(tid)
          && (ID_BITS >= 16 || tid[15:(ID_BITS < 16 ? ID_BITS : 15)] == '0))
        seg_used[i_lo] <= 1'b0;
      if (cmd.cmp_step && seg_used[i_lo]) begin
        seg_base[w_lo] <= addr;
        seg_size[w_lo] <= cur_size;
        seg_ident[w_lo] <= seg_ident[i_lo];
        seg_used[w_lo] <= 1'b1;
      end
      if (cmd.cmp_top) begin
        if (any_free && widx < CW'(MAX_SEGMENTS)) begin
          seg_base[w_lo] <= addr;
          seg_size[w_lo] <= freemem;
          seg_used[w_lo] <= 1'b0;
          seg_ident[w_lo] <= fresh;
          id_counter <= fresh;
          seg_count <= widx + CW'(1);
        end else begin
          seg_count <= widx;
        end
      end
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request_size;
      tid <= target_id;
      found <= 1'b0;
      hit <= 1'b0;
      any_free <= 1'b0;
      addr <= '0;
      freemem <= '0;
      widx <= '0;
      pick <= '0;
      idx <= '0;
    end else begin
      if (cmd.scan_step) begin
        if (fits && better) begin
          pick <= idx;
          found <= 1'b1;
        end
        idx <= idx + CW'(1);
      end
      if (cmd.park) idx <= seg_count;
      if (cmd.shift_step) idx <= idx - CW'(1);
      if (cmd.rel_step) begin
        if (seg_ident[i_lo][ID_BITS-1:0] == ID_BITS'(tid)
            && (ID_BITS >= 16 || tid[15:(ID_BITS < 16 ? ID_BITS : 15)] == '0))
          hit <= 1'b1;
        idx <= idx + CW'(1);
      end
      if (cmd.cmp_step) begin
        if (seg_used[i_lo]) begin
          addr <= addr + cur_size;
          widx <= widx + CW'(1);
        end else begin
          freemem <= freemem + cur_size;
          any_free <= 1'b1;
        end
        idx <= idx + CW'(1);
      end
    end
    if (cmd.set_result) begin
      res_status <= cmd.status;
      if (cmd.status == cfa_pkg::ST_OK && cmd.mark) begin
        res_id <= 16'(seg_ident[p_lo]);
        res_base <= seg_base[p_lo];
      end else begin
        res_id <= '0;
        res_base <= '0;
      end
    end
  end
endmodule

[hdl/cfa_ctrl.sv]
module cfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    kind,
  output logic          out_valid,
  input  logic          out_ready,
  input  cfa_pkg::sts_t sts,
  output cfa_pkg::cmd_t cmd
);
  cfa_pkg::state_t state, state_next;
  logic ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfa_pkg::S_IDLE;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
    end
  end

  assign out_valid = ov;
  assign in_ready = (state == cfa_pkg::S_IDLE) && !ov;

  always_comb begin
    state_next = state;
    ov_next = ov && !out_ready;
    cmd = '0;
    cmd.status = cfa_pkg::ST_OK;
    unique case (state)
      cfa_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          unique case (cfa_pkg::kind_t'(kind))
            cfa_pkg::KIND_INIT: state_next = cfa_pkg::S_INIT;
            cfa_pkg::KIND_ALLOC: state_next = cfa_pkg::S_SCAN;
            cfa_pkg::KIND_RELEASE: state_next = cfa_pkg::S_RELEASE;
            cfa_pkg::KIND_COMPACT: state_next = cfa_pkg::S_COMPACT;
          endcase
        end
      end
      cfa_pkg::S_INIT: begin
        cmd.do_init = 1'b1;
        cmd.set_result = 1'b1;
        state_next = cfa_pkg::S_DONE;
      end
      cfa_pkg::S_SCAN: begin
        if (sts.idx_end || sts.early) state_next = cfa_pkg::S_SPLIT_CHK;
        else cmd.scan_step = 1'b1;
      end
      cfa_pkg::S_SPLIT_CHK: begin
        if (!sts.found) begin
          cmd.set_result = 1'b1;
          cmd.status = cfa_pkg::ST_NOFIT;
          state_next = cfa_pkg::S_DONE;
        end else if (sts.exact) begin
          state_next = cfa_pkg::S_MARK;
        end else if (sts.full) begin
          cmd.set_result = 1'b1;
          cmd.status = cfa_pkg::ST_FULL;
          state_next = cfa_pkg::S_DONE;
        end else begin
          cmd.park = 1'b1;
          state_next = cfa_pkg::S_SHIFT;
        end
      end
      cfa_pkg::S_SHIFT: begin
        // idx starts at seg_count and walks down to pick + 1
        if (sts.shift_end) state_next = cfa_pkg::S_SPLIT_WR;
        else cmd.shift_step = 1'b1;
      end
      cfa_pkg::S_SPLIT_WR: begin
        cmd.split_wr = 1'b1;
        state_next = cfa_pkg::S_MARK;
      end
      cfa_pkg::S_MARK: begin
        cmd.mark = 1'b1;
        cmd.set_result = 1'b1;
        state_next = cfa_pkg::S_DONE;
      end
      cfa_pkg::S_RELEASE: begin
        if (sts.idx_end) begin
          cmd.set_result = 1'b1;
          cmd.status = sts.hit ? cfa_pkg::ST_OK : cfa_pkg::ST_NOID;
          state_next = cfa_pkg::S_DONE;
        end else cmd.rel_step = 1'b1;
      end
      cfa_pkg::S_COMPACT: begin
        if (sts.idx_end) state_next = cfa_pkg::S_COMPACT_TOP;
        else cmd.cmp_step = 1'b1;
      end
      cfa_pkg::S_COMPACT_TOP: begin
        cmd.cmp_top = 1'b1;
        cmd.set_result = 1'b1;
        state_next = cfa_pkg::S_DONE;
      end
      cfa_pkg::S_DONE: begin
        ov_next = 1'b1;
        state_next = cfa_pkg::S_IDLE;
      end
      default: state_next = cfa_pkg::S_IDLE;
    endcase
  end
endmodule

[hdl/contiguous_fit_allocator_core.sv]
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    kind, request_size, target_id
// out       output     out_valid/out_ready  status, segment_id, base_address
// cfg       input      apb write/read       fit_policy (0x0), total_space (0x4)
// an allocate goes one entry a cycle in the fit scan,
// then one entry a cycle to open a hole for the remainder
// release and compact walk the table once, one entry a cycle
// reset clears the table to empty and the id counter to zero
// a result waiting on out_ready holds off the next item
`include "contiguous_fit_allocator_core_defines.svh"
module contiguous_fit_allocator_core #(
  parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF,
  parameter int ID_BITS = cfa_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] request_size,
  input  logic [15:0] target_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] segment_id,
  output logic [31:0] base_address,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [1:0] fit_policy;
  logic [31:0] total_space;
  cfa_pkg::cmd_t cmd;
  cfa_pkg::sts_t sts;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= cfa_pkg::POL_FIRST;
      total_space <= cfa_pkg::TOTAL_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) fit_policy <= pwdata[1:0];
      else if (paddr == 3'd4) total_space <= pwdata;
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {30'd0, fit_policy};
    else if (paddr == 3'd4) prdata = total_space;
  end

  cfa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind, .out_valid, .out_ready, .sts, .cmd
  );

  cfa_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .ID_BITS(ID_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .fit_policy, .total_space, .request_size, .target_id,
    .res_status(status), .res_id(segment_id), .res_base(base_address)
  );

  `CFA_ASSERT(a_busy_no_accept, clk, rst, out_valid |-> !in_ready, "accept while result pending")
  `CFA_ASSERT(a_result_once, clk, rst, (out_valid && out_ready) |=> !out_valid, "result repeated")
  `CFA_ASSERT(a_err_zero, clk, rst, (out_valid && status != cfa_pkg::ST_OK) |-> (segment_id == 16'd0 && base_address == 32'd0), "payload not cleared on error")
endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import cfa_pkg::*;

  localparam int NSEG = MAX_SEGMENTS_DEF;
  localparam logic [2:0] ADDR_POLICY = 3'd0;
  localparam logic [2:0] ADDR_TOTAL = 3'd4;

  typedef struct {
    kind_t kind;
    logic [31:0] req;
    logic [15:0] tid;
  } request_t;

  typedef struct {
    status_t st;
    logic [15:0] id;
    logic [31:0] base;
  } answer_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [1:0] kind = 0;
  logic [31:0] request_size = 0;
  logic [15:0] target_id = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] status;
  logic [15:0] segment_id;
  logic [31:0] base_address;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  contiguous_fit_allocator_core u_top (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // allocator shadow state
  logic [31:0] sh_base [NSEG];
  logic [31:0] sh_size [NSEG];
  logic sh_used [NSEG];
  logic [15:0] sh_ident [NSEG];
  int sh_count;
  logic [15:0] sh_idc;
  policy_t sh_policy;
  logic [31:0] sh_total;

  request_t pending_q[$];
  answer_t answer_q[$];
  request_t cur;
  int errors = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit no_gaps = 0;
  bit in_fire = 0;

  function automatic logic [15:0] next_id();
    sh_idc = sh_idc + 16'd1;
    return sh_idc;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int pick, w;
    bit found, hit;
    logic [31:0] addr, freemem;
    a = '{ST_OK, 16'd0, 32'd0};
    case (r.kind)
      KIND_INIT: begin
        sh_base[0] = 0;
        sh_size[0] = sh_total;
        sh_used[0] = 0;
        sh_ident[0] = 0;
        sh_count = 1;
        sh_idc = 0;
      end
      KIND_ALLOC: begin
        found = 0;
        pick = 0;
        for (int i = 0; i < sh_count; i++) begin
          if (sh_used[i] || sh_size[i] < r.req) continue;
          if (!found) begin
            pick = i;
            found = 1;
            if (sh_policy != POL_BEST && sh_policy != POL_WORST) break;
          end else if (sh_policy == POL_BEST && sh_size[i] < sh_size[pick]) begin
            pick = i;
          end else if (sh_policy == POL_WORST && sh_size[i] > sh_size[pick]) begin
            pick = i;
          end
        end
        if (!found) begin
          a.st = ST_NOFIT;
          return a;
        end
        if (sh_size[pick] != r.req) begin
          if (sh_count >= NSEG) begin
            a.st = ST_FULL;
            return a;
          end
          for (int j = sh_count; j > pick + 1; j--) begin
            sh_base[j] = sh_base[j-1];
            sh_size[j] = sh_size[j-1];
            sh_used[j] = sh_used[j-1];
            sh_ident[j] = sh_ident[j-1];
          end
          sh_base[pick+1] = sh_base[pick] + r.req;
          sh_size[pick+1] = sh_size[pick] - r.req;
          sh_used[pick+1] = 0;
          sh_ident[pick+1] = next_id();
          sh_size[pick] = r.req;
          sh_count++;
        end
        sh_used[pick] = 1;
        a.id = sh_ident[pick];
        a.base = sh_base[pick];
      end
      KIND_RELEASE: begin
        hit = 0;
        for (int i = 0; i < sh_count; i++)
          if (sh_ident[i] == r.tid) begin
            sh_used[i] = 0;
            hit = 1;
          end
        if (!hit) a.st = ST_NOID;
      end
      default: begin
        w = 0;
        addr = 0;
        freemem = 0;
        found = 0;
        for (int i = 0; i < sh_count; i++) begin
          if (sh_used[i]) begin
            sh_base[w] = addr;
            sh_size[w] = sh_size[i];
            sh_used[w] = 1;
            sh_ident[w] = sh_ident[i];
            addr = addr + sh_size[i];
            w++;
          end else begin
            freemem = freemem + sh_size[i];
            found = 1;
          end
        end
        if (found && w < NSEG) begin
          sh_base[w] = addr;
          sh_size[w] = freemem;
          sh_used[w] = 0;
          sh_ident[w] = next_id();
          w++;
        end
        sh_count = w;
      end
    endcase
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input transaction accepted: predict on the payload held at this edge
  always @(posedge clk) begin
    in_fire = in_valid && in_ready;
    if (in_fire) answer_q.push_back(apply_request(cur));
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        in_valid <= 0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur = pending_q.pop_front();
        kind <= cur.kind;
        request_size <= cur.req;
        target_id <= cur.tid;
        in_valid <= 1;
        gap_left = pick_gap();
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 0;
      hold_left--;
    end else begin
      out_ready <= no_gaps || ($urandom_range(0, 99) < 65) ||
                   ($urandom_range(0, 99) < 40 ? 1'b0 : ($urandom_range(0, 9) == 0));
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result with no expectation: status %0d", status);
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d actual %0d", e.st, status);
          errors++;
        end
        if (segment_id !== e.id) begin
          $error("segment_id: expected %0d actual %0d", e.id, segment_id);
          errors++;
        end
        if (base_address !== e.base) begin
          $error("base_address: expected %0h actual %0h", e.base, base_address);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    penable <= 0;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == ADDR_POLICY) sh_policy = policy_t'(data[1:0]);
    else sh_total = data;
  endtask

  task automatic send(kind_t k, logic [31:0] req, logic [15:0] tid);
    pending_q.push_back('{k, req, tid});
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_items(int n);
    logic [31:0] req;
    logic [15:0] tid;
    int r;
    kind_t k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 52) k = KIND_ALLOC;
      else if (r < 84) k = KIND_RELEASE;
      else if (r < 95) k = KIND_COMPACT;
      else k = KIND_INIT;
      r = $urandom_range(0, 99);
      if (r < 70) req = $urandom_range(0, sh_total / 4);
      else if (r < 82) req = $urandom_range(0, 16);
      else req = $urandom;
      tid = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 40)) : 16'($urandom);
      send(k, req, tid);
    end
  endtask

  initial begin
    logic [31:0] totals [4];
    sh_count = 0;
    sh_idc = 0;
    sh_policy = POL_FIRST;
    sh_total = TOTAL_RESET;
    for (int i = 0; i < NSEG; i++) sh_used[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // empty table cases, then basic split / release / compact
    send(KIND_ALLOC, 32'd5, 0);
    send(KIND_RELEASE, 0, 16'd0);
    send(KIND_COMPACT, 0, 0);
    send(KIND_INIT, 0, 0);
    send(KIND_ALLOC, 32'd0, 0);
    send(KIND_ALLOC, 32'd100, 0);
    send(KIND_RELEASE, 0, 16'd1);
    send(KIND_RELEASE, 0, 16'hFFFF);
    send(KIND_ALLOC, 32'hFFFF_FFFF, 0);
    send(KIND_COMPACT, 0, 0);
    drain();

    // fill the table, then hit table full and an exact fit
    reg_write(ADDR_TOTAL, 32'd64);
    reg_write(ADDR_POLICY, POL_SPARE);
    send(KIND_INIT, 0, 0);
    for (int i = 0; i < 15; i++) send(KIND_ALLOC, 32'd1, 0);
    send(KIND_ALLOC, 32'd1, 0);
    send(KIND_ALLOC, 32'd49, 0);
    send(KIND_RELEASE, 0, 16'd3);
    send(KIND_COMPACT, 0, 0);
    drain();

    totals[0] = 32'd4096;
    totals[1] = 32'hFFFF_FFFF;
    totals[2] = 32'd0;
    for (int ph = 0; ph < 8; ph++) begin
      totals[3] = $urandom;
      reg_write(ADDR_POLICY, policy_t'(ph % 4));
      reg_write(ADDR_TOTAL, (ph == 6) ? totals[2] : totals[$urandom_range(0, 3) == 2 ? 0 :
                $urandom_range(0, 3)]);
      no_gaps = (ph == 3);
      send(KIND_INIT, 0, 0);
      random_items(172);
      if (ph == 1) hold_left = 400;
      drain();
    end
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
